@@ hdl/mcsw_pkg.sv @@
// Package for the multi-channel watchdog: operation codes, flags, widths and shared types.
package mcsw_pkg;

  localparam int ID_W        = 4;
  localparam int TIME_W      = 32;
  localparam int OP_W        = 3;
  localparam int MODE_W      = 3;
  localparam int NUM_ENTRIES = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Flag bit positions inside an entry.
  localparam int FLAG_SUSPEND = 0;
  localparam int FLAG_ARMED   = 1;
  localparam int FLAG_ENABLED = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_FEED    = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DISABLE = 3'd3,
    OP_CHECK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // Write command broadcast to every cell; only the selected cell acts on it.
  typedef struct packed {
    logic              wr_add;
    logic              wr_feed;
    logic              wr_enable;
    logic              wr_disable;
    logic [TIME_W-1:0] timeout;
    logic [TIME_W-1:0] now;
    logic [MODE_W-1:0] mode;
  } cmd_t;

endpackage

@@ hdl/multi_channel_soft_watchdog_top.sv @@
// Top level of the multi-channel watchdog: request decode, scan control and result output.
//
// Usage. A request is taken at a rising edge where start is high and busy is low.
// in_op selects add, feed, enable, disable or check; the other in_ fields carry
// the entry index, the timeout, the initial flags and the current time.
// Every result appears on the out_ ports for exactly one cycle with out_valid
// high; out_last marks the final result of a request. The receiver cannot stall
// the block, so results are never held back.
//
// Request handling. Add, feed, enable, disable and unused codes produce
// their single result in the cycle after acceptance, and busy stays low, so one
// such request can be taken every cycle. A check passes a token down the row of
// entry cells, one cell per cycle, and each cell compares its own elapsed time
// against its timeout. A check keeps busy high for the walk and for a drain
// state that delivers the final result; an empty table answers without a scan.
// Each expired entry is held back until the next expiry or the drain, so
// that the last one can carry out_last; a check reports at most sixteen entries.
//
// Reset (rst_n low, synchronous) empties the table and returns to idle; entry
// contents are left as they are and are only read after being added again.
module multi_channel_soft_watchdog_top #(
  parameter int NUM_ENTRIES = mcsw_pkg::NUM_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mcsw_pkg::OP_W-1:0]    in_op,
  input  logic [mcsw_pkg::ID_W-1:0]    in_entry_id,
  input  logic [mcsw_pkg::TIME_W-1:0]  in_timeout_ms,
  input  logic [mcsw_pkg::MODE_W-1:0]  in_mode_bits,
  input  logic [mcsw_pkg::TIME_W-1:0]  in_now_ms,
  output logic                         out_valid,
  output logic                         out_ok,
  output logic [mcsw_pkg::ID_W-1:0]    out_new_id,
  output logic                         out_fired,
  output logic [mcsw_pkg::ID_W-1:0]    out_fired_id,
  output logic                         out_last
);
  import mcsw_pkg::*;

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [RES_W-1:0]   rcnt_r, rcnt_nxt;
  logic [TIME_W-1:0]  scan_now_r, scan_now_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]    pend_id_r, pend_id_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [ID_W-1:0]    out_new_id_r, out_new_id_nxt;
  logic               out_fired_r, out_fired_nxt;
  logic [ID_W-1:0]    out_fired_id_r, out_fired_id_nxt;
  logic               out_last_r, out_last_nxt;

  cmd_t               cmd;
  logic [IDX_W-1:0]   sel;
  logic               inject;
  logic               abort;
  logic               accept;
  logic               known;
  logic               fire_any;
  logic               scan_end;
  logic [CMP_W-1:0]   id_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   scan_ext;
  logic [NUM_ENTRIES-1:0] tok_vec;
  logic [NUM_ENTRIES-1:0] fire_vec;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign id_ext   = CMP_W'(in_entry_id);
  assign cnt_ext  = CMP_W'(count_r);
  assign scan_ext = CMP_W'(scan_idx_r);
  assign known    = (id_ext < cnt_ext);
  assign fire_any = |fire_vec;
  // The scan stops after the last live entry or once the result limit is met.
  assign scan_end = (scan_ext == cnt_ext - CMP_W'(1)) ||
                    (fire_any && (rcnt_r == RES_W'(MAX_RESULTS - 1)));

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    scan_idx_nxt     = scan_idx_r;
    rcnt_nxt         = rcnt_r;
    scan_now_nxt     = scan_now_r;
    pend_v_nxt       = pend_v_r;
    pend_id_nxt      = pend_id_r;
    out_valid_nxt    = 1'b0;
    out_ok_nxt       = 1'b0;
    out_new_id_nxt   = '0;
    out_fired_nxt    = 1'b0;
    out_fired_id_nxt = '0;
    out_last_nxt     = 1'b0;
    cmd              = '0;
    cmd.timeout      = in_timeout_ms;
    cmd.now          = in_now_ms;
    cmd.mode         = in_mode_bits;
    sel              = id_ext[IDX_W-1:0];
    inject           = 1'b0;
    abort            = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          case (op_t'(in_op))
            OP_ADD: begin
              sel = cnt_ext[IDX_W-1:0];
              if (count_r < CNT_W'(NUM_ENTRIES)) begin
                cmd.wr_add     = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
                out_ok_nxt     = 1'b1;
                out_new_id_nxt = cnt_ext[ID_W-1:0];
              end
            end
            OP_FEED: begin
              cmd.wr_feed = known;
              out_ok_nxt  = known;
            end
            OP_ENABLE: begin
              cmd.wr_enable = known;
              out_ok_nxt    = known;
            end
            OP_DISABLE: begin
              cmd.wr_disable = known;
              out_ok_nxt     = known;
            end
            OP_CHECK: begin
              out_ok_nxt = 1'b1;
              if (count_r != '0) begin
                // Hold the answer back and start the token at entry zero.
                out_valid_nxt = 1'b0;
                out_last_nxt  = 1'b0;
                inject        = 1'b1;
                scan_idx_nxt  = '0;
                rcnt_nxt      = '0;
                pend_v_nxt    = 1'b0;
                scan_now_nxt  = in_now_ms;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (fire_any) begin
          // A new expiry releases the one held before it, which cannot be last.
          if (pend_v_r) begin
            out_valid_nxt    = 1'b1;
            out_ok_nxt       = 1'b1;
            out_fired_nxt    = 1'b1;
            out_fired_id_nxt = pend_id_r;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = scan_ext[ID_W-1:0];
          rcnt_nxt    = rcnt_r + RES_W'(1);
        end
        if (scan_end) begin
          abort     = 1'b1;
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        out_valid_nxt    = 1'b1;
        out_ok_nxt       = 1'b1;
        out_fired_nxt    = pend_v_r;
        out_fired_id_nxt = pend_v_r ? pend_id_r : '0;
        out_last_nxt     = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Row of entry cells; the scan token moves one cell per cycle.
  for (genvar gi = 0; gi < NUM_ENTRIES; gi++) begin : g_cell
    mcsw_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (gi)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel),
      .tok_in   ((gi == 0) ? inject : tok_vec[(gi == 0) ? 0 : gi - 1]),
      .abort    (abort),
      .scan_now (scan_now_r),
      .tok_out  (tok_vec[gi]),
      .fire     (fire_vec[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r     <= scan_idx_nxt;
    rcnt_r         <= rcnt_nxt;
    scan_now_r     <= scan_now_nxt;
    pend_id_r      <= pend_id_nxt;
    out_ok_r       <= out_ok_nxt;
    out_new_id_r   <= out_new_id_nxt;
    out_fired_r    <= out_fired_nxt;
    out_fired_id_r <= out_fired_id_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_new_id   = out_new_id_r;
  assign out_fired    = out_fired_r;
  assign out_fired_id = out_fired_id_r;
  assign out_last     = out_last_r;

  // At most one cell holds the scan token, and only during a scan.
  a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec) && ((state_r == ST_SCAN) || (tok_vec == '0)))
    else $error("scan token duplicated or outside a scan");

  // Only the token holder can report an expiry.
  a_fire_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(fire_vec) && ((fire_vec & ~tok_vec) == '0))
    else $error("expiry reported by a cell without the token");

  // The drain cycle always delivers the final result of a check.
  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (out_valid && out_last && out_ok))
    else $error("check finished without a final result");

  // A non-empty check makes the block busy and silent in the next cycle.
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_CHECK) && (count_r != '0)) |=> (busy && !out_valid))
    else $error("check did not enter the scan");

endmodule

@@ hdl/mcsw_cell.sv @@
// One watchdog entry: its timeout, last feed time, flags and the scan token stage.
module mcsw_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mcsw_pkg::cmd_t             cmd,
  input  logic [IDX_W-1:0]           sel,
  input  logic                       tok_in,
  input  logic                       abort,
  input  logic [mcsw_pkg::TIME_W-1:0] scan_now,
  output logic                       tok_out,
  output logic                       fire
);
  import mcsw_pkg::*;

  logic [TIME_W-1:0] timeout_r, timeout_nxt;
  logic [TIME_W-1:0] feed_r, feed_nxt;
  logic [MODE_W-1:0] flags_r, flags_nxt;
  logic              tok_r, tok_nxt;
  logic              hit;
  logic [TIME_W-1:0] elapsed;

  assign hit     = (sel == IDX_W'(CELL_IDX));
  assign elapsed = scan_now - feed_r;
  assign fire    = tok_r && flags_r[FLAG_ARMED] && flags_r[FLAG_ENABLED] &&
                   (elapsed > timeout_r);
  assign tok_out = tok_r;

  always_comb begin
    timeout_nxt = timeout_r;
    feed_nxt    = feed_r;
    flags_nxt   = flags_r;
    tok_nxt     = abort ? 1'b0 : tok_in;
    if (hit && cmd.wr_add) begin
      timeout_nxt = cmd.timeout;
      feed_nxt    = cmd.now;
      flags_nxt   = cmd.mode;
    end else if (hit && cmd.wr_feed) begin
      feed_nxt = cmd.now;
      if (flags_r[FLAG_SUSPEND]) begin
        flags_nxt[FLAG_ARMED] = 1'b1;
      end
    end else if (hit && cmd.wr_enable) begin
      flags_nxt[FLAG_ENABLED] = 1'b1;
    end else if (hit && cmd.wr_disable) begin
      flags_nxt[FLAG_ENABLED] = 1'b0;
    end else if (fire && flags_r[FLAG_SUSPEND]) begin
      // A reported entry in suspend mode disarms until its next feed.
      flags_nxt[FLAG_ARMED] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    timeout_r <= timeout_nxt;
    feed_r    <= feed_nxt;
    flags_r   <= flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

endmodule
